[src/rbd_pkg.sv]
// Shared types, constants and the control store for the ring buffer deque.
// Holds the microcode table, the dispatch table and the datapath control structs.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package rbd_pkg;

    // Queue geometry and field widths.
    localparam int CAPACITY   = 4096;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(CAPACITY);
    localparam int CNT_W      = PTR_W + 1;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 13;
    localparam int REQ_W      = 3;
    localparam int STAT_W     = 2;
    localparam int STEP_W     = 5;

    // Stream word layouts, padded to whole bytes.
    localparam int IN_DATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VAL_W + CNT_W + STAT_W + 7) / 8) * 8;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_READ_FRONT = 3'd4,
        REQ_READ_BACK  = 3'd5,
        REQ_READ_INDEX = 3'd6,
        REQ_RESIZE     = 3'd7
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Jump conditions tested by the sequencer.
    typedef enum logic [2:0] {
        COND_NEVER   = 3'd0,
        COND_ALWAYS  = 3'd1,
        COND_EMPTY   = 3'd2,
        COND_FULL    = 3'd3,
        COND_POS_OOR = 3'd4,
        COND_POS_BIG = 3'd5,
        COND_CNT_LT  = 3'd6,
        COND_CNT_GT  = 3'd7
    } t_cond;

    // Pointer and count operations of the datapath.
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_ADD_BACK   = 3'd1,
        OP_ADD_FRONT  = 3'd2,
        OP_DROP_BACK  = 3'd3,
        OP_DROP_FRONT = 3'd4
    } t_op;

    // Source of the store read address.
    typedef enum logic [1:0] {
        RD_HEAD  = 2'd0,
        RD_TAIL  = 2'd1,
        RD_INDEX = 2'd2
    } t_rdsel;

    // One control word of the microprogram.
    typedef struct packed {
        logic    wait_in;
        t_cond   cond;
        t_step   target;
        t_op     op;
        t_rdsel  rd_sel;
        logic    emit;
        logic    val_sel;
        t_status status;
    } t_uword;

    // Control word plus the step-advance qualifier, sent to the datapath.
    typedef struct packed {
        t_uword uw;
        logic   advance;
    } t_ctrl;

    // Datapath status tested by jump conditions.
    typedef struct packed {
        logic empty;
        logic full;
        logic pos_oor;
        logic pos_big;
        logic cnt_lt;
        logic cnt_gt;
    } t_flags;

    // Microprogram step addresses.
    localparam t_step S_IDLE      = 5'd0;
    localparam t_step S_PB_CHK    = 5'd1;
    localparam t_step S_PB_DO     = 5'd2;
    localparam t_step S_PF_CHK    = 5'd3;
    localparam t_step S_PF_DO     = 5'd4;
    localparam t_step S_OB_CHK    = 5'd5;
    localparam t_step S_OB_DO     = 5'd6;
    localparam t_step S_OF_CHK    = 5'd7;
    localparam t_step S_OF_DO     = 5'd8;
    localparam t_step S_RF_CHK    = 5'd9;
    localparam t_step S_RF_OUT    = 5'd10;
    localparam t_step S_RB_CHK    = 5'd11;
    localparam t_step S_RB_OUT    = 5'd12;
    localparam t_step S_RI_CHK    = 5'd13;
    localparam t_step S_RI_RNG    = 5'd14;
    localparam t_step S_RI_OUT    = 5'd15;
    localparam t_step S_RS_CHK    = 5'd16;
    localparam t_step S_RS_LOOP   = 5'd17;
    localparam t_step S_RS_TST_GT = 5'd18;
    localparam t_step S_RS_DONE   = 5'd19;
    localparam t_step S_RS_GROW   = 5'd20;
    localparam t_step S_RS_SHRINK = 5'd21;
    localparam t_step S_ERR_EMPTY = 5'd22;
    localparam t_step S_ERR_FULL  = 5'd23;
    localparam t_step S_ERR_RANGE = 5'd24;

    // Builds a control word that does not wait for input.
    function automatic t_uword mk(t_cond c, t_step tgt, t_op op, t_rdsel rs,
                                  logic emit, logic vsel, t_status st);
        t_uword w;
        w.wait_in = 1'b0;
        w.cond    = c;
        w.target  = tgt;
        w.op      = op;
        w.rd_sel  = rs;
        w.emit    = emit;
        w.val_sel = vsel;
        w.status  = st;
        return w;
    endfunction

    // Control store. Emit steps return to idle once the output register can take the result word.
    function automatic t_uword ucode(t_step a);
        t_uword w;
        w = mk(COND_ALWAYS, S_IDLE, OP_NONE, RD_HEAD, 1'b0, 1'b0, ST_OK);
        unique case (a)
            S_IDLE: begin
                w.wait_in = 1'b1;
                w.cond    = COND_NEVER;
            end
            S_PB_CHK:    w = mk(COND_FULL, S_ERR_FULL, OP_NONE, RD_HEAD, 1'b0, 1'b0, ST_OK);
            S_PB_DO:     w = mk(COND_NEVER, S_IDLE, OP_ADD_BACK, RD_HEAD, 1'b1, 1'b0, ST_OK);
            S_PF_CHK:    w = mk(COND_FULL, S_ERR_FULL, OP_NONE, RD_HEAD, 1'b0, 1'b0, ST_OK);
            S_PF_DO:     w = mk(COND_NEVER, S_IDLE, OP_ADD_FRONT, RD_HEAD, 1'b1, 1'b0, ST_OK);
            S_OB_CHK:    w = mk(COND_EMPTY, S_ERR_EMPTY, OP_NONE, RD_HEAD, 1'b0, 1'b0, ST_OK);
            S_OB_DO:     w = mk(COND_NEVER, S_IDLE, OP_DROP_BACK, RD_HEAD, 1'b1, 1'b0, ST_OK);
            S_OF_CHK:    w = mk(COND_EMPTY, S_ERR_EMPTY, OP_NONE, RD_HEAD, 1'b0, 1'b0, ST_OK);
            S_OF_DO:     w = mk(COND_NEVER, S_IDLE, OP_DROP_FRONT, RD_HEAD, 1'b1, 1'b0, ST_OK);
            S_RF_CHK:    w = mk(COND_EMPTY, S_ERR_EMPTY, OP_NONE, RD_HEAD, 1'b0, 1'b0, ST_OK);
            S_RF_OUT:    w = mk(COND_NEVER, S_IDLE, OP_NONE, RD_HEAD, 1'b1, 1'b1, ST_OK);
            S_RB_CHK:    w = mk(COND_EMPTY, S_ERR_EMPTY, OP_NONE, RD_TAIL, 1'b0, 1'b0, ST_OK);
            S_RB_OUT:    w = mk(COND_NEVER, S_IDLE, OP_NONE, RD_TAIL, 1'b1, 1'b1, ST_OK);
            S_RI_CHK:    w = mk(COND_EMPTY, S_ERR_EMPTY, OP_NONE, RD_INDEX, 1'b0, 1'b0, ST_OK);
            S_RI_RNG:    w = mk(COND_POS_OOR, S_ERR_RANGE, OP_NONE, RD_INDEX, 1'b0, 1'b0,
                                ST_OK);
            S_RI_OUT:    w = mk(COND_NEVER, S_IDLE, OP_NONE, RD_INDEX, 1'b1, 1'b1, ST_OK);
            S_RS_CHK:    w = mk(COND_POS_BIG, S_ERR_FULL, OP_NONE, RD_HEAD, 1'b0, 1'b0, ST_OK);
            S_RS_LOOP:   w = mk(COND_CNT_LT, S_RS_GROW, OP_NONE, RD_HEAD, 1'b0, 1'b0, ST_OK);
            S_RS_TST_GT: w = mk(COND_CNT_GT, S_RS_SHRINK, OP_NONE, RD_HEAD, 1'b0, 1'b0,
                                ST_OK);
            S_RS_DONE:   w = mk(COND_NEVER, S_IDLE, OP_NONE, RD_HEAD, 1'b1, 1'b0, ST_OK);
            S_RS_GROW:   w = mk(COND_ALWAYS, S_RS_LOOP, OP_ADD_BACK, RD_HEAD, 1'b0, 1'b0,
                                ST_OK);
            S_RS_SHRINK: w = mk(COND_ALWAYS, S_RS_LOOP, OP_DROP_BACK, RD_HEAD, 1'b0, 1'b0,
                                ST_OK);
            S_ERR_EMPTY: w = mk(COND_NEVER, S_IDLE, OP_NONE, RD_HEAD, 1'b1, 1'b0, ST_EMPTY);
            S_ERR_FULL:  w = mk(COND_NEVER, S_IDLE, OP_NONE, RD_HEAD, 1'b1, 1'b0, ST_FULL);
            S_ERR_RANGE: w = mk(COND_NEVER, S_IDLE, OP_NONE, RD_HEAD, 1'b1, 1'b0, ST_RANGE);
            default: begin
                // Unused addresses fall back to idle.
                w = mk(COND_ALWAYS, S_IDLE, OP_NONE, RD_HEAD, 1'b0, 1'b0, ST_OK);
            end
        endcase
        return w;
    endfunction

    // Dispatch table: first step of each request's routine.
    function automatic t_step entry_of(t_req r);
        t_step s;
        unique case (r)
            REQ_PUSH_BACK:  s = S_PB_CHK;
            REQ_PUSH_FRONT: s = S_PF_CHK;
            REQ_POP_BACK:   s = S_OB_CHK;
            REQ_POP_FRONT:  s = S_OF_CHK;
            REQ_READ_FRONT: s = S_RF_CHK;
            REQ_READ_BACK:  s = S_RB_CHK;
            REQ_READ_INDEX: s = S_RI_CHK;
            REQ_RESIZE:     s = S_RS_CHK;
            default:        s = S_IDLE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[src/rbd_sequencer.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on rbd_pkg for the control word, the flags and the microprogram.
`default_nettype none

module rbd_sequencer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [rbd_pkg::REQ_W-1:0]  i_req,
    input  wire logic                       i_out_free,
    input  wire rbd_pkg::t_flags            i_flags,
    output logic                            o_in_ready,
    output rbd_pkg::t_ctrl                  o_ctrl
);

    rbd_pkg::t_step  r_step;
    rbd_pkg::t_step  n_step;
    rbd_pkg::t_uword uw;
    logic            hit;
    logic            advance;

    // Fetch the current control word.
    assign uw = rbd_pkg::ucode(r_step);

    // An emitting step moves on only when the output register can take the word.
    assign advance = !uw.emit || i_out_free;

    // The input is ready only in the idle step and never while reset is held.
    assign o_in_ready     = uw.wait_in && i_rst_n;
    assign o_ctrl.uw      = uw;
    assign o_ctrl.advance = advance && !uw.wait_in;

    // Evaluate the jump condition.
    always_comb begin
        unique case (uw.cond)
            rbd_pkg::COND_NEVER:   hit = 1'b0;
            rbd_pkg::COND_ALWAYS:  hit = 1'b1;
            rbd_pkg::COND_EMPTY:   hit = i_flags.empty;
            rbd_pkg::COND_FULL:    hit = i_flags.full;
            rbd_pkg::COND_POS_OOR: hit = i_flags.pos_oor;
            rbd_pkg::COND_POS_BIG: hit = i_flags.pos_big;
            rbd_pkg::COND_CNT_LT:  hit = i_flags.cnt_lt;
            rbd_pkg::COND_CNT_GT:  hit = i_flags.cnt_gt;
            default:               hit = 1'b0;
        endcase
    end

    // Next step: dispatch on a new word, hold on a stall, else jump or fall through.
    always_comb begin
        priority if (uw.wait_in) begin
            n_step = i_in_valid ? rbd_pkg::entry_of(rbd_pkg::t_req'(i_req)) : r_step;
        end else if (!advance) begin
            n_step = r_step;
        end else if (uw.emit) begin
            n_step = rbd_pkg::S_IDLE;
        end else if (hit) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + rbd_pkg::t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= rbd_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

[src/rbd_datapath.sv]
// Datapath: entry store, head and tail pointers, entry count and status flags.
// Depends on rbd_pkg for widths, the control word and the flag struct.
`default_nettype none

module rbd_datapath #(
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire rbd_pkg::t_ctrl             i_ctrl,
    input  wire logic [rbd_pkg::VAL_W-1:0]  i_data,
    input  wire logic [rbd_pkg::POS_W-1:0]  i_pos,
    output rbd_pkg::t_flags                 o_flags,
    output logic [rbd_pkg::VAL_W-1:0]       o_rd_value,
    output logic [rbd_pkg::CNT_W-1:0]       o_count_next
);

    localparam int PTR_W = rbd_pkg::PTR_W;
    localparam int CNT_W = rbd_pkg::CNT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rbd_pkg::CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(rbd_pkg::CAPACITY);

    logic [DATA_WIDTH-1:0] mem [rbd_pkg::CAPACITY];
    logic [DATA_WIDTH-1:0] r_mem_q;

    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] n_head;
    logic [PTR_W-1:0] r_tail;
    logic [PTR_W-1:0] n_tail;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic [PTR_W-1:0]      head_inc;
    logic [PTR_W-1:0]      head_dec;
    logic [PTR_W-1:0]      tail_inc;
    logic [PTR_W-1:0]      tail_dec;
    logic [PTR_W:0]        idx_sum;
    logic [PTR_W-1:0]      idx_addr;
    logic [PTR_W-1:0]      rd_addr;
    logic                  we;
    logic [PTR_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  empty;
    logic                  single;

    // Wrapping pointer neighbors.
    assign head_inc = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
    assign head_dec = (r_head == '0) ? PTR_LAST : r_head - PTR_W'(1);
    assign tail_inc = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
    assign tail_dec = (r_tail == '0) ? PTR_LAST : r_tail - PTR_W'(1);

    assign empty  = (r_count == '0);
    assign single = (r_count == CNT_W'(1));

    // Indexed address: head plus position, wrapped once into the store.
    assign idx_sum  = {1'b0, r_head} + {1'b0, i_pos[PTR_W-1:0]};
    assign idx_addr = (idx_sum >= (PTR_W+1)'(rbd_pkg::CAPACITY))
                    ? PTR_W'(idx_sum - (PTR_W+1)'(rbd_pkg::CAPACITY))
                    : idx_sum[PTR_W-1:0];

    always_comb begin
        unique case (i_ctrl.uw.rd_sel)
            rbd_pkg::RD_HEAD:  rd_addr = r_head;
            rbd_pkg::RD_TAIL:  rd_addr = r_tail;
            rbd_pkg::RD_INDEX: rd_addr = idx_addr;
            default:           rd_addr = r_head;
        endcase
    end

    assign wdata = DATA_WIDTH'(i_data);

    // Pointer, count and write control for the current step.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        we      = 1'b0;
        waddr   = r_tail;
        if (i_ctrl.advance) begin
            unique case (i_ctrl.uw.op)
                rbd_pkg::OP_NONE: begin
                end
                rbd_pkg::OP_ADD_BACK: begin
                    n_head  = empty ? '0 : r_head;
                    n_tail  = empty ? '0 : tail_inc;
                    waddr   = n_tail;
                    we      = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
                rbd_pkg::OP_ADD_FRONT: begin
                    n_head  = empty ? '0 : head_dec;
                    n_tail  = empty ? '0 : r_tail;
                    waddr   = n_head;
                    we      = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
                rbd_pkg::OP_DROP_BACK: begin
                    n_head  = single ? '0 : r_head;
                    n_tail  = single ? '0 : tail_dec;
                    n_count = r_count - CNT_W'(1);
                end
                rbd_pkg::OP_DROP_FRONT: begin
                    n_head  = single ? '0 : head_inc;
                    n_tail  = single ? '0 : r_tail;
                    n_count = r_count - CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Entry store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_mem_q <= mem[rd_addr];
    end

    // Status flags from the registered count and the held position.
    assign o_flags.empty   = empty;
    assign o_flags.full    = (r_count >= CNT_CAP);
    assign o_flags.pos_oor = (i_pos >= r_count);
    assign o_flags.pos_big = (i_pos > CNT_CAP);
    assign o_flags.cnt_lt  = (r_count < i_pos);
    assign o_flags.cnt_gt  = (r_count > i_pos);

    assign o_rd_value   = i_ctrl.uw.val_sel ? rbd_pkg::VAL_W'(r_mem_q) : '0;
    assign o_count_next = n_count;

endmodule

`default_nettype wire

[src/ring_buffer_deque_top.sv]
// Top level of the ring buffer deque: stream ports, request and result registers.
// Instantiates rbd_sequencer and rbd_datapath; depends on rbd_pkg.
//
//   Channel   Dir  Word layout (lowest bit first)                      Accepted when
//   s_axis    in   tuser: req_type[2:0]; tdata: data_value[31:0],      tvalid && tready
//                  position[44:32], zero pad [47:45]
//   m_axis    out  tdata: read_value[31:0], occupancy[44:32],          tvalid && tready
//                  status[46:45], zero pad [47]
//
// The microprogram runs one control word per cycle, except that the idle step waits for a
// request word and an emitting step holds while the output register is full. Resize adds
// an entry with a grow step and one compare step, and removes one with a shrink step and
// two compare steps. One request is in flight at a time; the next word is accepted while
// a finished result waits in the output register. A full output register stalls only the
// emitting step. Reset is synchronous and clears the pointers, the count, the step counter
// and the output valid flag; the input is not ready while reset is held and the entry
// store is not cleared.
`default_nettype none

module ring_buffer_deque_top #(
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // data_value[31:0], position[44:32], zero pad
    input  wire logic [rbd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type[2:0]
    input  wire logic [rbd_pkg::REQ_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // read_value[31:0], occupancy[44:32], status[46:45], zero pad
    output logic [rbd_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    localparam int VAL_W  = rbd_pkg::VAL_W;
    localparam int POS_W  = rbd_pkg::POS_W;
    localparam int CNT_W  = rbd_pkg::CNT_W;
    localparam int STAT_W = rbd_pkg::STAT_W;
    localparam int PAD_W  = rbd_pkg::OUT_DATA_W - VAL_W - CNT_W - STAT_W;

    logic [VAL_W-1:0]  r_data;
    logic [POS_W-1:0]  r_pos;
    logic              in_fire;

    logic                          r_out_valid;
    logic [rbd_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                          out_free;
    logic                          out_load;

    rbd_pkg::t_ctrl    ctrl;
    rbd_pkg::t_flags   flags;
    logic [VAL_W-1:0]  rd_value;
    logic [CNT_W-1:0]  count_next;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign out_load = ctrl.uw.emit && ctrl.advance;

    // Hold the request word while its routine runs.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_data <= s_axis_tdata[VAL_W-1:0];
            r_pos  <= s_axis_tdata[VAL_W+POS_W-1:VAL_W];
        end
    end

    rbd_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req      (s_axis_tuser),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (ctrl)
    );

    rbd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_data       (r_data),
        .i_pos        (r_pos),
        .o_flags      (flags),
        .o_rd_value   (rd_value),
        .o_count_next (count_next)
    );

    // Result register: loaded by an emitting step, emptied by the downstream side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {{PAD_W{1'b0}}, STAT_W'(ctrl.uw.status), count_next, rd_value};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

[tb/sv/tb_ring_buffer_deque_top.sv]
// Self-checking testbench for ring_buffer_deque_top: a mirror deque predicts each result word.
// Covers empty and full cases, pointer wrap, range errors and resize by streamed requests.
// Depends on rbd_pkg and ring_buffer_deque_top.
`default_nettype none

// One request word as the sender offers it.
typedef struct packed {
    rbd_pkg::t_req               kind;
    logic [rbd_pkg::VAL_W-1:0]   value;
    logic [rbd_pkg::POS_W-1:0]   pos;
} t_deque_request;

// One result word as the mirror expects it.
typedef struct packed {
    logic [rbd_pkg::VAL_W-1:0]   value;
    logic [rbd_pkg::CNT_W-1:0]   occupancy;
    rbd_pkg::t_status            status;
} t_deque_reply;

// Mirror of the deque: its own circular store, pointers and count, plus the
// replies that accepted requests still owe.
class deque_mirror;
    logic [rbd_pkg::VAL_W-1:0]   slots [rbd_pkg::CAPACITY];
    logic [rbd_pkg::PTR_W-1:0]   head;
    logic [rbd_pkg::PTR_W-1:0]   tail;
    int unsigned                 fill;
    t_deque_reply                awaited [$];
    int unsigned                 mismatches;

    function new();
        head       = '0;
        tail       = '0;
        fill       = 0;
        mismatches = 0;
    endfunction

    // An empty queue restarts both pointers at slot zero.
    function void append_back(logic [rbd_pkg::VAL_W-1:0] v);
        if (fill == 0) begin
            head = '0;
            tail = '0;
        end else begin
            tail = tail + 1'b1;
        end
        slots[tail] = v;
        fill++;
    endfunction

    function void remove_back();
        if (fill == 1) begin
            head = '0;
            tail = '0;
        end else begin
            tail = tail - 1'b1;
        end
        fill--;
    endfunction

    // Updates the mirror for an accepted request and queues the reply it owes.
    function void apply_request(t_deque_request rq);
        t_deque_reply                rp;
        logic [rbd_pkg::PTR_W-1:0]   idx;
        rp.value  = '0;
        rp.status = rbd_pkg::ST_OK;
        case (rq.kind)
            rbd_pkg::REQ_PUSH_BACK: begin
                if (fill >= rbd_pkg::CAPACITY) rp.status = rbd_pkg::ST_FULL;
                else append_back(rq.value);
            end
            rbd_pkg::REQ_PUSH_FRONT: begin
                if (fill >= rbd_pkg::CAPACITY) begin
                    rp.status = rbd_pkg::ST_FULL;
                end else begin
                    if (fill == 0) begin
                        head = '0;
                        tail = '0;
                    end else begin
                        head = head - 1'b1;
                    end
                    slots[head] = rq.value;
                    fill++;
                end
            end
            rbd_pkg::REQ_POP_BACK: begin
                if (fill == 0) rp.status = rbd_pkg::ST_EMPTY;
                else remove_back();
            end
            rbd_pkg::REQ_POP_FRONT: begin
                if (fill == 0) begin
                    rp.status = rbd_pkg::ST_EMPTY;
                end else begin
                    if (fill == 1) begin
                        head = '0;
                        tail = '0;
                    end else begin
                        head = head + 1'b1;
                    end
                    fill--;
                end
            end
            rbd_pkg::REQ_READ_FRONT: begin
                if (fill == 0) rp.status = rbd_pkg::ST_EMPTY;
                else rp.value = slots[head];
            end
            rbd_pkg::REQ_READ_BACK: begin
                if (fill == 0) rp.status = rbd_pkg::ST_EMPTY;
                else rp.value = slots[tail];
            end
            rbd_pkg::REQ_READ_INDEX: begin
                if (fill == 0) begin
                    rp.status = rbd_pkg::ST_EMPTY;
                end else if (rq.pos >= fill) begin
                    rp.status = rbd_pkg::ST_RANGE;
                end else begin
                    idx      = head + rq.pos[rbd_pkg::PTR_W-1:0];
                    rp.value = slots[idx];
                end
            end
            default: begin
                // Resize grows with copies of the fill value and shrinks from the back.
                if (rq.pos > rbd_pkg::CAPACITY) begin
                    rp.status = rbd_pkg::ST_FULL;
                end else begin
                    while (fill < rq.pos) append_back(rq.value);
                    while (fill > rq.pos) remove_back();
                end
            end
        endcase
        rp.occupancy = rbd_pkg::CNT_W'(fill);
        awaited.insert(awaited.size(), rp);
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    // Compares a result word with the oldest reply still owed.
    function void check_reply(logic [rbd_pkg::OUT_DATA_W-1:0] word);
        t_deque_reply rp;
        if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: result word mismatch, expected none, actual %0h", $time, word);
            return;
        end
        rp = awaited[0];
        awaited.delete(0);
        if (word[31:0] !== rp.value) flag("read_value", rp.value, word[31:0]);
        if (word[44:32] !== rp.occupancy) flag("occupancy", rp.occupancy, word[44:32]);
        if (word[46:45] !== rp.status) flag("status", rp.status, word[46:45]);
    endfunction
endclass

module tb_ring_buffer_deque_top;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    // data_value[31:0], position[44:32], zero pad
    logic [rbd_pkg::IN_DATA_W-1:0]      s_axis_tdata;
    // req_type[2:0]
    logic [rbd_pkg::REQ_W-1:0]          s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    // read_value[31:0], occupancy[44:32], status[46:45], zero pad
    logic [rbd_pkg::OUT_DATA_W-1:0]     m_axis_tdata;

    bit                     hold_off_req;
    bit                     no_idle;
    deque_mirror            mirror = new();
    t_deque_request         plan [$];

    ring_buffer_deque_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run, large resizes included.
    initial begin
        #30_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Every result word taken at a rising edge goes to the mirror.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) mirror.check_reply(m_axis_tdata);
    end

    // Receiver: random back-pressure, plus one long hold-off that fills the block.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                hold_off_req = 1'b0;
                repeat (400) @(negedge i_clk);
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 18);
            end
        end
    end

    function automatic t_deque_request mk_req(rbd_pkg::t_req k,
                                              logic [rbd_pkg::VAL_W-1:0] v,
                                              logic [rbd_pkg::POS_W-1:0] p);
        t_deque_request rq;
        rq.kind  = k;
        rq.value = v;
        rq.pos   = p;
        return rq;
    endfunction

    // Appends a request to the plan.
    function automatic void plan_add(t_deque_request rq);
        plan.insert(plan.size(), rq);
    endfunction

    // Takes the oldest request from the plan.
    function automatic t_deque_request plan_take();
        t_deque_request rq;
        rq = plan[0];
        plan.delete(0);
        return rq;
    endfunction

    // Offers one request word, with an occasional gap first, and waits until it is taken.
    task automatic send_request(t_deque_request rq);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 99) < 18) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(rbd_pkg::IN_DATA_W - rbd_pkg::VAL_W - rbd_pkg::POS_W){1'b0}},
                          rq.pos, rq.value};
        s_axis_tuser  <= rq.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        mirror.apply_request(rq);
    endtask

    initial begin
        t_deque_request rq;
        int unsigned    cnt;
        int unsigned    roll;
        int unsigned    lo;
        int unsigned    hi;
        int             n;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_rst_n       = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every pop and read request on an empty queue first.
        plan_add(mk_req(rbd_pkg::REQ_POP_BACK,   32'h0, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_POP_FRONT,  32'h0, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_READ_FRONT, 32'h0, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_READ_BACK,  32'h0, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_READ_INDEX, 32'h0, 13'd0));
        // Pushes at both ends; the front push wraps the head pointer.
        plan_add(mk_req(rbd_pkg::REQ_PUSH_BACK,  32'hFFFF_FFFF, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_PUSH_FRONT, 32'h0000_0000, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_PUSH_BACK,  32'hA5A5_A5A5, 13'h1FFF));
        plan_add(mk_req(rbd_pkg::REQ_READ_FRONT, 32'h0, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_READ_BACK,  32'h0, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_READ_INDEX, 32'h0, 13'd1));
        plan_add(mk_req(rbd_pkg::REQ_READ_INDEX, 32'h0, 13'd3));
        plan_add(mk_req(rbd_pkg::REQ_READ_INDEX, 32'h0, 13'd4096));
        plan_add(mk_req(rbd_pkg::REQ_POP_FRONT,  32'h0, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_POP_BACK,   32'h0, 13'd0));
        // Resize to the current size, then pop the last entry.
        plan_add(mk_req(rbd_pkg::REQ_RESIZE,     32'h1234_5678, 13'd1));
        plan_add(mk_req(rbd_pkg::REQ_POP_BACK,   32'h0, 13'd0));
        // Fill to capacity and try to go past it.
        plan_add(mk_req(rbd_pkg::REQ_RESIZE,     32'h5A5A_5A5A, 13'd4096));
        plan_add(mk_req(rbd_pkg::REQ_PUSH_BACK,  32'hDEAD_BEEF, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_PUSH_FRONT, 32'hDEAD_BEEF, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_READ_INDEX, 32'h0, 13'd4095));
        plan_add(mk_req(rbd_pkg::REQ_RESIZE,     32'h0, 13'd4097));
        plan_add(mk_req(rbd_pkg::REQ_RESIZE,     32'h0, 13'h1FFF));
        // Pointers wrap while full, then drain and push front into an empty queue.
        plan_add(mk_req(rbd_pkg::REQ_POP_FRONT,  32'h0, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_PUSH_BACK,  32'h0F0F_F0F0, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_RESIZE,     32'h0, 13'd0));
        plan_add(mk_req(rbd_pkg::REQ_PUSH_FRONT, 32'h8000_0001, 13'd0));
        while (plan.size() != 0) send_request(plan_take());

        // Random requests; rare bursts run the queue up to near capacity and back.
        for (n = 0; n < 1800; n++) begin
            if (n == 300) hold_off_req = 1'b1;
            no_idle = (n >= 900 && n < 1200);
            if (plan.size() == 0 && $urandom_range(0, 299) == 0) begin
                plan_add(mk_req(rbd_pkg::REQ_RESIZE, $urandom,
                                rbd_pkg::POS_W'($urandom_range(3990, 4096))));
                plan_add(mk_req(rbd_pkg::REQ_PUSH_BACK, $urandom, '0));
                plan_add(mk_req(rbd_pkg::REQ_PUSH_FRONT, $urandom, '0));
                plan_add(mk_req(rbd_pkg::REQ_READ_INDEX, '0,
                                rbd_pkg::POS_W'($urandom_range(0, 4096))));
                plan_add(mk_req(rbd_pkg::REQ_POP_FRONT, '0, '0));
                plan_add(mk_req(rbd_pkg::REQ_READ_BACK, '0, '0));
                plan_add(mk_req(rbd_pkg::REQ_RESIZE, $urandom,
                                rbd_pkg::POS_W'($urandom_range(0, 32))));
            end
            if (plan.size() != 0) begin
                rq = plan_take();
            end else begin
                cnt  = mirror.fill;
                roll = $urandom_range(0, 99);
                rq   = mk_req(rbd_pkg::REQ_READ_FRONT, $urandom, rbd_pkg::POS_W'($urandom));
                if (roll < 52) begin
                    // Pushes outweigh pops, so a long queue leans back toward pops.
                    if (roll < 30 && !(cnt > 160 && $urandom_range(0, 1) == 1)) begin
                        rq.kind = $urandom_range(0, 1) ? rbd_pkg::REQ_PUSH_BACK
                                                       : rbd_pkg::REQ_PUSH_FRONT;
                    end else begin
                        rq.kind = $urandom_range(0, 1) ? rbd_pkg::REQ_POP_BACK
                                                       : rbd_pkg::REQ_POP_FRONT;
                    end
                end else if (roll < 60) begin
                    rq.kind = rbd_pkg::REQ_READ_FRONT;
                end else if (roll < 68) begin
                    rq.kind = rbd_pkg::REQ_READ_BACK;
                end else if (roll < 88) begin
                    rq.kind = rbd_pkg::REQ_READ_INDEX;
                    if (cnt != 0 && $urandom_range(0, 3) != 0) begin
                        rq.pos = rbd_pkg::POS_W'($urandom_range(0, cnt - 1));
                    end else begin
                        rq.pos = rbd_pkg::POS_W'($urandom_range(cnt, rbd_pkg::CAPACITY));
                    end
                end else if (roll < 97) begin
                    // Mostly small steps around the current size, sometimes a near reset.
                    rq.kind = rbd_pkg::REQ_RESIZE;
                    lo = (cnt > 24) ? cnt - 24 : 0;
                    hi = (cnt + 24 > rbd_pkg::CAPACITY) ? rbd_pkg::CAPACITY : cnt + 24;
                    if ($urandom_range(0, 7) == 0) rq.pos = rbd_pkg::POS_W'($urandom_range(0, 3));
                    else rq.pos = rbd_pkg::POS_W'($urandom_range(lo, hi));
                end else begin
                    rq.kind = rbd_pkg::REQ_RESIZE;
                    rq.pos  = rbd_pkg::POS_W'($urandom_range(rbd_pkg::CAPACITY + 1, 8191));
                end
            end
            send_request(rq);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // Drain the owed replies, then let the block run on idle before the verdict.
        while (mirror.awaited.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mirror.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

`default_nettype wire

[filelist.f]
src/rbd_pkg.sv
src/rbd_sequencer.sv
src/rbd_datapath.sv
src/ring_buffer_deque_top.sv
tb/sv/tb_ring_buffer_deque_top.sv
